// File: design/dda_line_rasterizer_top_defines.svh
// Assertion macros used by the line rasterizer top level.
`ifndef DDA_LINE_RASTERIZER_TOP_DEFINES_SVH
`define DDA_LINE_RASTERIZER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define DDA_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DDA_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/dda_lr_pkg.sv
// Shared widths, types and constants for the DDA line rasterizer.
`default_nettype none

package dda_lr_pkg;

   // Fraction bits of the fixed-point position and increments (8 to 24).
   localparam int FRAC_BITS = 16;

   localparam int COORD_W = 16;                 // pixel coordinate
   localparam int DIFF_W  = COORD_W + 1;        // endpoint difference
   localparam int MAG_W   = COORD_W;            // |difference| and step count
   localparam int DIM_W   = 15;                 // image width / height
   localparam int COLOR_W = 32;

   localparam int POS_W   = COORD_W + 2 + FRAC_BITS;  // running position
   localparam int INC_W   = FRAC_BITS + 2;            // signed increment
   localparam int QUOT_W  = FRAC_BITS + 1;            // |increment| <= 2^FRAC_BITS
   localparam int RND_W   = POS_W - FRAC_BITS;        // rounded coordinate
   localparam int NUM_W   = MAG_W + FRAC_BITS;        // dividend
   localparam int CNT_W   = $clog2(QUOT_W);

   localparam int REQ_DATA_W = 4 * COORD_W + COLOR_W;
   localparam int RSP_BITS   = 2 * COORD_W + COLOR_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [INC_W-1:0]  inc_type;
   typedef logic [QUOT_W-1:0] quot_type;
   typedef logic [NUM_W-1:0]  num_type;
   typedef logic [MAG_W-1:0]  mag_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   localparam pos_type ROUND_HALF = pos_type'(1) << (FRAC_BITS - 1);
   localparam cnt_type DIV_LAST   = cnt_type'(FRAC_BITS);

   // Divider request from the sequencer.
   typedef struct packed {
      logic    start;
      mag_type mag;
      mag_type divisor;
   } div_req_type;

   // Divider status back to the sequencer.
   typedef struct packed {
      logic     done;
      quot_type quot;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: design/dda_lr_div.sv
// Bit-serial restoring divider giving a rounded fixed-point increment magnitude.
`default_nettype none

module dda_lr_div (
   input  logic                    clock,
   input  logic                    reset,
   input  dda_lr_pkg::div_req_type div_req,
   output dda_lr_pkg::div_rsp_type div_rsp
);

   dda_lr_pkg::mag_type  rem_ff, rem_in;
   dda_lr_pkg::quot_type quo_ff, quo_in;
   dda_lr_pkg::mag_type  dvs_ff, dvs_in;
   dda_lr_pkg::cnt_type  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [dda_lr_pkg::MAG_W:0] trial;
   logic [dda_lr_pkg::MAG_W:0] diff;
   logic                       ge;
   dda_lr_pkg::num_type        num;

   always_comb begin
      // dividend = |d| * 2^FRAC_BITS + steps/2, so the quotient rounds to nearest
      num   = {div_req.mag, {dda_lr_pkg::FRAC_BITS{1'b0}}}
            + dda_lr_pkg::num_type'(div_req.divisor[dda_lr_pkg::MAG_W-1:1]);
      trial = {rem_ff, quo_ff[dda_lr_pkg::QUOT_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = trial >= {1'b0, dvs_ff};

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (div_req.start) begin
         // quotient fits QUOT_W bits, so the top bits already sit below the divisor
         rem_in  = {1'b0, num[dda_lr_pkg::NUM_W-1:dda_lr_pkg::QUOT_W]};
         quo_in  = num[dda_lr_pkg::QUOT_W-1:0];
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[dda_lr_pkg::MAG_W-1:0] : trial[dda_lr_pkg::MAG_W-1:0];
         quo_in = {quo_ff[dda_lr_pkg::QUOT_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == dda_lr_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

`default_nettype wire

// File: design/dda_line_rasterizer_top.sv
// DDA line rasterizer top level: sequencer, position accumulators and output register.
// Start transfer: increments by one shared bit-serial divider at one quotient bit per cycle,
//   run once per axis unless the line has zero length. Step on a line: position registered,
//   then rounded, clipped and loaded in S_EMIT when the output is free. No request is taken
//   before that. Step, no line: empty result loaded at transfer edge, 1 per cycle if free.
// Synchronous active-high reset: idle, no line active, image size 640 x 480.
`default_nettype none
`include "dda_line_rasterizer_top_defines.svh"

module dda_line_rasterizer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // start_x, start_y, end_x, end_y, pixel_color
   input  logic [dda_lr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type
   input  logic [0:0]                            req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // point_x, point_y, point_color, visible, zero padding
   output logic [dda_lr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // last_point
   output logic                                  rsp_tlast,
   // valid_res
   output logic [0:0]                            rsp_tuser,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [0:0]                            csr_index,
   input  logic [15:0]                           csr_data
);

   localparam int F  = dda_lr_pkg::FRAC_BITS;
   localparam int CW = dda_lr_pkg::COORD_W;

   // request kinds
   localparam logic REQ_START = 1'b0;

   // register indexes
   localparam logic [0:0] CSR_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_DIVX  = 3'd2;
   localparam logic [2:0] S_DIVY  = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [dda_lr_pkg::DIM_W-1:0]       width_ff, width_in;
   logic [dda_lr_pkg::DIM_W-1:0]       height_ff, height_in;
   dda_lr_pkg::pos_type                pos_x_ff, pos_x_in;
   dda_lr_pkg::pos_type                pos_y_ff, pos_y_in;
   dda_lr_pkg::inc_type                inc_x_ff, inc_x_in;
   dda_lr_pkg::inc_type                inc_y_ff, inc_y_in;
   dda_lr_pkg::mag_type                points_left_ff, points_left_in;
   logic [dda_lr_pkg::COLOR_W-1:0]     color_ff, color_in;
   logic                               active_ff, active_in;
   logic [CW-1:0]                      sx_ff, sx_in;
   logic [CW-1:0]                      sy_ff, sy_in;
   logic [dda_lr_pkg::DIFF_W-1:0]      dx_ff, dx_in;
   logic [dda_lr_pkg::DIFF_W-1:0]      dy_ff, dy_in;
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [dda_lr_pkg::RSP_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic                               rsp_tlast_ff, rsp_tlast_in;
   logic                               rsp_tuser_ff, rsp_tuser_in;

   dda_lr_pkg::div_req_type            div_req;
   dda_lr_pkg::div_rsp_type            div_rsp;

   logic                               rsp_free;
   logic                               req_fire;
   logic [dda_lr_pkg::DIFF_W-1:0]      abs_x, abs_y;
   dda_lr_pkg::mag_type                mag_x, mag_y, steps;
   dda_lr_pkg::inc_type                quot_ext;
   logic [dda_lr_pkg::RND_W-1:0]       rnd_x, rnd_y;
   logic                               visible;
   logic [CW-1:0]                      in_sx, in_sy, in_ex, in_ey;

   // Round half away from zero: floor((p + half - [p < 0]) / 2^F).
   function automatic logic [dda_lr_pkg::RND_W-1:0] round_pos(
      input dda_lr_pkg::pos_type p
   );
      dda_lr_pkg::pos_type sum;
      sum = p + dda_lr_pkg::ROUND_HALF - dda_lr_pkg::pos_type'(p[dda_lr_pkg::POS_W-1]);
      return sum[dda_lr_pkg::POS_W-1:F];
   endfunction

   // Sign-extend an increment to the position width.
   function automatic dda_lr_pkg::pos_type inc_ext(input dda_lr_pkg::inc_type inc);
      return {{(dda_lr_pkg::POS_W - dda_lr_pkg::INC_W){inc[dda_lr_pkg::INC_W-1]}}, inc};
   endfunction

   dda_lr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign in_sx = req_tdata[CW-1:0];
   assign in_sy = req_tdata[2*CW-1:CW];
   assign in_ex = req_tdata[3*CW-1:2*CW];
   assign in_ey = req_tdata[4*CW-1:3*CW];

   // Accept a new item only with nothing in work and the output register free to load.
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      // step count is the larger of |dx| and |dy|; both fit 16 bits unsigned
      abs_x    = dx_ff[dda_lr_pkg::DIFF_W-1] ? (~dx_ff + 1'b1) : dx_ff;
      abs_y    = dy_ff[dda_lr_pkg::DIFF_W-1] ? (~dy_ff + 1'b1) : dy_ff;
      mag_x    = abs_x[dda_lr_pkg::MAG_W-1:0];
      mag_y    = abs_y[dda_lr_pkg::MAG_W-1:0];
      steps    = (mag_x > mag_y) ? mag_x : mag_y;
      quot_ext = {1'b0, div_rsp.quot};

      // visibility is judged on the full rounded value, not its low 16 bits
      rnd_x   = round_pos(pos_x_ff);
      rnd_y   = round_pos(pos_y_ff);
      visible = !rnd_x[dda_lr_pkg::RND_W-1] && !rnd_y[dda_lr_pkg::RND_W-1]
             && (rnd_x[dda_lr_pkg::RND_W-2:0] < (dda_lr_pkg::RND_W-1)'(width_ff))
             && (rnd_y[dda_lr_pkg::RND_W-2:0] < (dda_lr_pkg::RND_W-1)'(height_ff));
   end

   always_comb begin
      state_in       = state_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      inc_x_in       = inc_x_ff;
      inc_y_in       = inc_y_ff;
      points_left_in = points_left_ff;
      color_in       = color_ff;
      active_in      = active_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tlast_in   = rsp_tlast_ff;
      rsp_tuser_in   = rsp_tuser_ff;

      div_req.start   = 1'b0;
      div_req.mag     = mag_x;
      div_req.divisor = points_left_ff;

      // register writes are to arrive only while idle; the block itself does not enforce this
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_data[dda_lr_pkg::DIM_W-1:0];
            CSR_HEIGHT: height_in = csr_data[dda_lr_pkg::DIM_W-1:0];
            default:    width_in  = width_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == REQ_START) begin
                  // latch endpoints and colour; any active line is dropped
                  sx_in    = in_sx;
                  sy_in    = in_sy;
                  dx_in    = {in_ex[CW-1], in_ex} - {in_sx[CW-1], in_sx};
                  dy_in    = {in_ey[CW-1], in_ey} - {in_sy[CW-1], in_sy};
                  color_in = req_tdata[dda_lr_pkg::REQ_DATA_W-1:4*CW];
                  state_in = S_SETUP;
               end else if (active_ff) begin
                  // advance one point along the line
                  pos_x_in       = pos_x_ff + inc_ext(inc_x_ff);
                  pos_y_in       = pos_y_ff + inc_ext(inc_y_ff);
                  points_left_in = points_left_ff - 1'b1;
                  active_in      = points_left_ff != dda_lr_pkg::mag_type'(1);
                  state_in       = S_EMIT;
               end else begin
                  // no line to advance: return an empty result at once
                  rsp_tvalid_in = 1'b1;
                  rsp_tdata_in  = '0;
                  rsp_tlast_in  = 1'b0;
                  rsp_tuser_in  = 1'b0;
               end
            end
         end

         S_SETUP: begin
            pos_x_in       = {{2{sx_ff[CW-1]}}, sx_ff, {F{1'b0}}};
            pos_y_in       = {{2{sy_ff[CW-1]}}, sy_ff, {F{1'b0}}};
            points_left_in = steps;
            active_in      = steps != '0;
            if (steps == '0) begin
               // zero-length line: single point, no division
               inc_x_in = '0;
               inc_y_in = '0;
               state_in = S_EMIT;
            end else begin
               div_req.start   = 1'b1;
               div_req.mag     = mag_x;
               div_req.divisor = steps;
               state_in        = S_DIVX;
            end
         end

         S_DIVX: begin
            div_req.mag = mag_y;
            if (div_rsp.done) begin
               inc_x_in      = dx_ff[dda_lr_pkg::DIFF_W-1] ? (~quot_ext + 1'b1) : quot_ext;
               div_req.start = 1'b1;
               state_in      = S_DIVY;
            end
         end

         S_DIVY: begin
            div_req.mag = mag_y;
            if (div_rsp.done) begin
               inc_y_in = dy_ff[dda_lr_pkg::DIFF_W-1] ? (~quot_ext + 1'b1) : quot_ext;
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            // hold the point until the output register can take it
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{dda_lr_pkg::RSP_PAD_W{1'b0}}, visible, color_ff,
                                rnd_y[CW-1:0], rnd_x[CW-1:0]};
               rsp_tlast_in  = points_left_ff == '0;
               rsp_tuser_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      inc_x_ff     <= inc_x_in;
      inc_y_ff     <= inc_y_in;
      color_ff     <= color_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_tuser_ff <= rsp_tuser_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         width_ff       <= dda_lr_pkg::DIM_W'(640);
         height_ff      <= dda_lr_pkg::DIM_W'(480);
         points_left_ff <= '0;
         active_ff      <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         points_left_ff <= points_left_in;
         active_ff      <= active_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tlast    = rsp_tlast_ff;
   assign rsp_tuser[0] = rsp_tuser_ff;

   // divider finishes only while the sequencer waits on it
   `DDA_CHECK(a_div_done_in_wait, div_rsp.done |-> (state_ff == S_DIVX || state_ff == S_DIVY), "divider result outside a divide state")
   // an active line always has points still to come
   `DDA_CHECK(a_active_has_points, active_ff |-> (points_left_ff != '0), "active line with no points left")
   // emitting a point leaves the sequencer idle with a result on the output
   `DDA_CHECK(a_emit_to_idle, (state_ff == S_EMIT && rsp_free) |=> (state_ff == S_IDLE && rsp_tvalid_ff), "emit did not load a result")
   // reset leaves the block idle with an empty output register
   `DDA_CHECK_ALWAYS(a_reset_idle, reset |=> (state_ff == S_IDLE && !rsp_tvalid_ff && !active_ff), "block not idle after reset")

endmodule

`default_nettype wire
